// ===== hw/rtl/quaternion_arithmetic_unit_macros.svh =====
// Assertion macros shared by the checking code of the quaternion unit.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

`define QAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qau_pkg.sv =====
package qau_pkg;

    localparam int CompW = 16;
    localparam int FracB = 14;
    localparam int ProdW = 2 * CompW;
    localparam int SumW = ProdW + 2;
    localparam int RadW = 2 * CompW + 2;
    localparam int RootW = RadW / 2;
    localparam int RemW = RootW + 3;
    localparam int FrontDepth = 4;
    localparam int FrontIdxW = $clog2(FrontDepth);
    localparam int OutDepth = 32;
    localparam int OutIdxW = $clog2(OutDepth);
    localparam int CntW = $clog2(OutDepth + 1);
    localparam int NumProd = 16;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_CONJ = 2'd2,
        OP_NORM = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [CompW-1:0] a_w;
        logic signed [CompW-1:0] a_x;
        logic signed [CompW-1:0] a_y;
        logic signed [CompW-1:0] a_z;
        logic signed [CompW-1:0] b_w;
        logic signed [CompW-1:0] b_x;
        logic signed [CompW-1:0] b_y;
        logic signed [CompW-1:0] b_z;
    } t_req;

    typedef struct packed {
        logic signed [CompW-1:0] res_w;
        logic signed [CompW-1:0] res_x;
        logic signed [CompW-1:0] res_y;
        logic signed [CompW-1:0] res_z;
        logic [CompW-1:0]        norm_value;
        logic                    saturated;
    } t_rsp;

    typedef struct packed {
        logic is_add;
        logic is_mul;
        logic is_conj;
        logic is_norm;
    } t_cls;

    typedef struct packed {
        t_cls                    cls;
        logic signed [CompW-1:0] a_w;
        logic signed [CompW-1:0] a_x;
        logic signed [CompW-1:0] a_y;
        logic signed [CompW-1:0] a_z;
        logic signed [CompW-1:0] b_w;
        logic signed [CompW-1:0] b_x;
        logic signed [CompW-1:0] b_y;
        logic signed [CompW-1:0] b_z;
    } t_cmd;

    typedef struct packed {
        logic [CntW-1:0] used;
        logic [CntW-1:0] out_cnt;
        logic            take;
    } t_bstat;

    typedef struct packed {
        logic                    sat;
        logic signed [CompW-1:0] val;
    } t_clip;

    localparam logic signed [SumW-1:0] SumMax =
        {{(SumW - CompW + 1){1'b0}}, {(CompW - 1){1'b1}}};
    localparam logic signed [SumW-1:0] SumMin = ~SumMax;

    function automatic t_clip clip_comp(input logic signed [SumW-1:0] v);
        t_clip c;
        c.sat = 1'b0;
        c.val = v[CompW-1:0];
        if (v > SumMax) begin
            c.sat = 1'b1;
            c.val = SumMax[CompW-1:0];
        end else if (v < SumMin) begin
            c.sat = 1'b1;
            c.val = SumMin[CompW-1:0];
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/qau_front.sv =====
module qau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  qau_pkg::t_req i_req,
    output logic          o_cmd_vld,
    output qau_pkg::t_cmd o_cmd,
    input  logic          i_cmd_rdy
);
    import qau_pkg::*;

    t_cmd                r_mem [FrontDepth];
    logic [FrontIdxW-1:0] r_wr, r_rd;
    logic [FrontIdxW:0]   r_cnt, n_cnt;
    t_cmd                w_cmd;
    logic                w_put, w_get;

    always_comb begin
        w_cmd.cls = '0;
        unique case (t_op'(i_req.req_type))
            OP_ADD:  w_cmd.cls.is_add = 1'b1;
            OP_MUL:  w_cmd.cls.is_mul = 1'b1;
            OP_CONJ: w_cmd.cls.is_conj = 1'b1;
            OP_NORM: w_cmd.cls.is_norm = 1'b1;
            default: w_cmd.cls.is_norm = 1'b1;
        endcase
        w_cmd.a_w = i_req.a_w;
        w_cmd.a_x = i_req.a_x;
        w_cmd.a_y = i_req.a_y;
        w_cmd.a_z = i_req.a_z;
        w_cmd.b_w = i_req.b_w;
        w_cmd.b_x = i_req.b_x;
        w_cmd.b_y = i_req.b_y;
        w_cmd.b_z = i_req.b_z;
    end

    assign full = (r_cnt == (FrontIdxW + 1)'(FrontDepth));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd = r_mem[r_rd];
    assign w_put = push && !full;
    assign w_get = o_cmd_vld && i_cmd_rdy;

    always_comb begin
        n_cnt = r_cnt;
        if (w_put && !w_get) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_get && !w_put) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_put) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_get) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

endmodule

// ===== hw/rtl/qau_back.sv =====
module qau_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_vld,
    input  qau_pkg::t_cmd   i_cmd,
    output logic            o_cmd_rdy,
    output logic            empty,
    input  logic            pop,
    output qau_pkg::t_rsp   o_rsp,
    output qau_pkg::t_bstat o_stat
);
    import qau_pkg::*;

    typedef struct packed {
        logic            is_norm;
        t_rsp            rsp;
        logic [RadW-1:0] rad;
        logic [RemW-1:0] rem;
        logic [RootW-1:0] root;
    } t_sq;

    function automatic t_sq sq_step(input t_sq s);
        t_sq             o;
        logic [RemW-1:0] rem2;
        logic [RemW-1:0] trial;
        o = s;
        rem2 = {s.rem[RemW-3:0], s.rad[RadW-1:RadW-2]};
        trial = {{(RemW - RootW - 2){1'b0}}, s.root, 2'b01};
        o.rad = {s.rad[RadW-3:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem = rem2 - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end else begin
            o.rem = rem2;
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic                    w_take;
    logic [CntW-1:0]         r_used, r_cnt;
    logic [OutIdxW-1:0]      r_wr, r_rd;
    t_rsp                    r_mem [OutDepth];

    logic                    r_a_vld;
    t_cmd                    r_a_cmd;
    logic signed [ProdW-1:0] r_a_p [NumProd];
    logic [ProdW-1:0]        r_a_sq [4];

    logic                    r_sq_vld [RootW];
    t_sq                     r_sq [RootW];
    t_sq                     w_b;
    t_clip                   w_c0, w_c1, w_c2, w_c3;
    logic signed [SumW-1:0]  w_s0, w_s1, w_s2, w_s3;
    t_rsp                    w_out;
    logic                    w_put, w_get;

    assign w_take = i_cmd_vld && (r_used != CntW'(OutDepth));
    assign o_cmd_rdy = (r_used != CntW'(OutDepth));
    assign w_get = pop && !empty;
    assign empty = (r_cnt == '0);
    assign o_rsp = r_mem[r_rd];
    assign o_stat.used = r_used;
    assign o_stat.out_cnt = r_cnt;
    assign o_stat.take = w_take;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_cmd <= i_cmd;
            r_a_p[0] <= i_cmd.a_w * i_cmd.b_w;
            r_a_p[1] <= i_cmd.a_x * i_cmd.b_x;
            r_a_p[2] <= i_cmd.a_y * i_cmd.b_y;
            r_a_p[3] <= i_cmd.a_z * i_cmd.b_z;
            r_a_p[4] <= i_cmd.a_w * i_cmd.b_x;
            r_a_p[5] <= i_cmd.b_w * i_cmd.a_x;
            r_a_p[6] <= i_cmd.a_y * i_cmd.b_z;
            r_a_p[7] <= i_cmd.a_z * i_cmd.b_y;
            r_a_p[8] <= i_cmd.a_w * i_cmd.b_y;
            r_a_p[9] <= i_cmd.b_w * i_cmd.a_y;
            r_a_p[10] <= i_cmd.a_z * i_cmd.b_x;
            r_a_p[11] <= i_cmd.a_x * i_cmd.b_z;
            r_a_p[12] <= i_cmd.a_w * i_cmd.b_z;
            r_a_p[13] <= i_cmd.b_w * i_cmd.a_z;
            r_a_p[14] <= i_cmd.a_x * i_cmd.b_y;
            r_a_p[15] <= i_cmd.a_y * i_cmd.b_x;
            r_a_sq[0] <= $unsigned(ProdW'(i_cmd.a_w) * ProdW'(i_cmd.a_w));
            r_a_sq[1] <= $unsigned(ProdW'(i_cmd.a_x) * ProdW'(i_cmd.a_x));
            r_a_sq[2] <= $unsigned(ProdW'(i_cmd.a_y) * ProdW'(i_cmd.a_y));
            r_a_sq[3] <= $unsigned(ProdW'(i_cmd.a_z) * ProdW'(i_cmd.a_z));
        end
    end

    always_comb begin
        w_s0 = '0;
        w_s1 = '0;
        w_s2 = '0;
        w_s3 = '0;
        w_b.is_norm = r_a_cmd.cls.is_norm;
        w_b.rad = '0;
        w_b.rem = '0;
        w_b.root = '0;
        w_b.rsp = '0;
        priority if (r_a_cmd.cls.is_add) begin
            w_s0 = r_a_cmd.a_w + r_a_cmd.b_w;
            w_s1 = r_a_cmd.a_x + r_a_cmd.b_x;
            w_s2 = r_a_cmd.a_y + r_a_cmd.b_y;
            w_s3 = r_a_cmd.a_z + r_a_cmd.b_z;
        end else if (r_a_cmd.cls.is_mul) begin
            w_s0 = (r_a_p[0] - r_a_p[1] - r_a_p[2] - r_a_p[3]) >>> FracB;
            w_s1 = (r_a_p[4] + r_a_p[5] + r_a_p[6] - r_a_p[7]) >>> FracB;
            w_s2 = (r_a_p[8] + r_a_p[9] + r_a_p[10] - r_a_p[11]) >>> FracB;
            w_s3 = (r_a_p[12] + r_a_p[13] + r_a_p[14] - r_a_p[15]) >>> FracB;
        end else if (r_a_cmd.cls.is_conj) begin
            w_s0 = r_a_cmd.a_w;
            w_s1 = -r_a_cmd.a_x;
            w_s2 = -r_a_cmd.a_y;
            w_s3 = -r_a_cmd.a_z;
        end else begin
            w_b.rad = RadW'(r_a_sq[0]) + RadW'(r_a_sq[1]) + RadW'(r_a_sq[2])
                + RadW'(r_a_sq[3]);
        end
        w_c0 = clip_comp(w_s0);
        w_c1 = clip_comp(w_s1);
        w_c2 = clip_comp(w_s2);
        w_c3 = clip_comp(w_s3);
        w_b.rsp.res_w = w_c0.val;
        w_b.rsp.res_x = w_c1.val;
        w_b.rsp.res_y = w_c2.val;
        w_b.rsp.res_z = w_c3.val;
        w_b.rsp.saturated = w_c0.sat | w_c1.sat | w_c2.sat | w_c3.sat;
    end

    always_ff @(posedge i_clk) begin
        r_sq[0] <= sq_step(w_b);
        for (int k = 1; k < RootW; k++) begin
            r_sq[k] <= sq_step(r_sq[k-1]);
        end
    end

    always_comb begin
        w_out = r_sq[RootW-1].rsp;
        if (r_sq[RootW-1].is_norm) begin
            if (r_sq[RootW-1].root[RootW-1]) begin
                w_out.norm_value = '1;
                w_out.saturated = 1'b1;
            end else begin
                w_out.norm_value = r_sq[RootW-1].root[CompW-1:0];
            end
        end
    end

    assign w_put = r_sq_vld[RootW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int k = 0; k < RootW; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            r_used <= '0;
            r_cnt <= '0;
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_a_vld <= w_take;
            r_sq_vld[0] <= r_a_vld;
            for (int k = 1; k < RootW; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
            r_used <= r_used + CntW'(w_take) - CntW'(w_get);
            r_cnt <= r_cnt + CntW'(w_put) - CntW'(w_get);
            if (w_put) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_get) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= w_out;
        end
    end

endmodule

// ===== hw/rtl/quaternion_arithmetic_unit.sv =====
// A pushed item passes the front queue, the product register, the square-root pipeline and the result queue.
// Throughput: one item per cycle while the front queue is not full and result credits remain.
// The 17-stage square-root pipeline sets the latency; a 32-entry result queue with credit
// counting keeps it from ever stalling. Reset is synchronous and active low; it empties both queues and the pipeline.
`include "quaternion_arithmetic_unit_macros.svh"

module quaternion_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  qau_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output qau_pkg::t_rsp o_rsp
);
    import qau_pkg::*;

    logic   w_cmd_vld, w_cmd_rdy;
    t_cmd   w_cmd;
    t_bstat w_stat;

    qau_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_rdy (w_cmd_rdy)
    );

    qau_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_rdy (w_cmd_rdy),
        .empty     (empty),
        .pop       (pop),
        .o_rsp     (o_rsp),
        .o_stat    (w_stat)
    );

    `QAU_ASSERT_NOW(a_cnt_le_used, i_clk, i_rst_n, 1'b1, w_stat.out_cnt <= w_stat.used, "queue count exceeds credits")
    `QAU_ASSERT_NOW(a_used_le_depth, i_clk, i_rst_n, 1'b1, w_stat.used <= CntW'(OutDepth), "credits overrun")
    `QAU_ASSERT_NEXT(a_take_counts, i_clk, i_rst_n, w_stat.take, w_stat.used != '0, "transfer not counted")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import qau_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_req i_req;
    logic empty;
    logic pop;
    t_rsp o_rsp;

    quaternion_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_req  (i_req),
        .empty  (empty),
        .pop    (pop),
        .o_rsp  (o_rsp)
    );

    localparam int NumRandom = 1950;
    localparam int HoldCycles = 300;

    typedef struct {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_row;

    t_rsp expected_q[$];
    int n_fail;
    int n_sent;
    int n_checked;
    int n_sat;
    int op_count[4];
    bit stim_done;
    bit hold_on;
    bit hold_done;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [15:0] clip16(input longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic longint fixed_floor(input longint v);
        return v >>> FracB;
    endfunction

    function automatic t_rsp quat_result(input t_req q);
        t_rsp r;
        logic sat;
        longint aw, ax, ay, az, bw, bx, by, bz;
        longint sumsq;
        longint root;
        sat = 1'b0;
        r = '0;
        aw = q.a_w; ax = q.a_x; ay = q.a_y; az = q.a_z;
        bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
        case (t_op'(q.req_type))
            OP_ADD: begin
                r.res_w = clip16(aw + bw, sat);
                r.res_x = clip16(ax + bx, sat);
                r.res_y = clip16(ay + by, sat);
                r.res_z = clip16(az + bz, sat);
            end
            OP_MUL: begin
                r.res_w = clip16(fixed_floor(aw*bw - ax*bx - ay*by - az*bz), sat);
                r.res_x = clip16(fixed_floor(aw*bx + bw*ax + ay*bz - az*by), sat);
                r.res_y = clip16(fixed_floor(aw*by + bw*ay + az*bx - ax*bz), sat);
                r.res_z = clip16(fixed_floor(aw*bz + bw*az + ax*by - ay*bx), sat);
            end
            OP_CONJ: begin
                r.res_w = q.a_w;
                r.res_x = clip16(-ax, sat);
                r.res_y = clip16(-ay, sat);
                r.res_z = clip16(-az, sat);
            end
            default: begin
                sumsq = aw*aw + ax*ax + ay*ay + az*az;
                root = 0;
                for (int b = 16; b >= 0; b--) begin
                    if ((root + (64'sd1 <<< b)) * (root + (64'sd1 <<< b)) <= sumsq)
                        root = root + (64'sd1 <<< b);
                end
                if (root > 65535) begin
                    sat = 1'b1;
                    root = 65535;
                end
                r.norm_value = root[15:0];
            end
        endcase
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [15:0] random_comp();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh4000;
            3: return 16'shc000;
            4: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_req();
        t_req q;
        q.req_type = 2'($urandom_range(0, 3));
        q.a_w = random_comp(); q.a_x = random_comp();
        q.a_y = random_comp(); q.a_z = random_comp();
        q.b_w = random_comp(); q.b_x = random_comp();
        q.b_y = random_comp(); q.b_z = random_comp();
        return q;
    endfunction

    function automatic t_rsp fixed_rsp(input logic [15:0] w, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] z,
                                       input logic [15:0] n, input logic s);
        t_rsp r;
        r.res_w = w; r.res_x = x; r.res_y = y; r.res_z = z;
        r.norm_value = n; r.saturated = s;
        return r;
    endfunction

    function automatic t_req make_req(input t_op op, input logic [15:0] v0,
                                      input logic [15:0] v1, input logic [15:0] v2,
                                      input logic [15:0] v3, input logic [15:0] u0,
                                      input logic [15:0] u1, input logic [15:0] u2,
                                      input logic [15:0] u3);
        t_req q;
        q.req_type = op;
        q.a_w = v0; q.a_x = v1; q.a_y = v2; q.a_z = v3;
        q.b_w = u0; q.b_x = u1; q.b_y = u2; q.b_z = u3;
        return q;
    endfunction

    task automatic add_row(input t_req q, input logic known, input t_rsp r);
        t_row row;
        row.req = q;
        row.known = known;
        row.rsp = r;
        rows.push_back(row);
    endtask

    task automatic transfer_req(input t_req q, input t_rsp want);
        i_req <= q;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        expected_q.push_back(want);
        op_count[q.req_type]++;
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        push <= 1'b0;
        i_req <= random_req();
        @(negedge i_clk);
    endtask

    task automatic build_rows();
        t_rsp z;
        z = '0;
        add_row(make_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z);
        add_row(make_req(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                         16'h0001, 16'hffff, 16'h8001, 16'h7fff), 1'b1,
                fixed_rsp(16'h7fff, 16'h8000, 16'h0000, 16'hffff, 0, 1'b1));
        add_row(make_req(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1,
                fixed_rsp(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 1'b1));
        add_row(make_req(OP_MUL, 16'h4000, 0, 0, 0, 16'h1234, 16'h8000, 16'h7fff, 16'h0001),
                1'b1, fixed_rsp(16'h1234, 16'h8000, 16'h7fff, 16'h0001, 0, 1'b0));
        add_row(make_req(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, z);
        add_row(make_req(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, z);
        add_row(make_req(OP_MUL, 16'h0001, 16'hffff, 16'h0001, 16'hffff,
                         16'hffff, 16'h0001, 16'hffff, 16'h0001), 1'b0, z);
        add_row(make_req(OP_MUL, 0, 16'h4000, 0, 0, 0, 0, 16'h4000, 0), 1'b1,
                fixed_rsp(0, 0, 0, 16'h4000, 0, 1'b0));
        add_row(make_req(OP_CONJ, 16'h8000, 16'h8000, 16'h7fff, 16'h0001,
                         16'h1111, 16'h2222, 16'h3333, 16'h4444), 1'b1,
                fixed_rsp(16'h8000, 16'h7fff, 16'h8001, 16'hffff, 0, 1'b1));
        add_row(make_req(OP_CONJ, 16'h7fff, 0, 16'hffff, 16'h8001, 0, 0, 0, 0), 1'b1,
                fixed_rsp(16'h7fff, 0, 16'h0001, 16'h7fff, 0, 1'b0));
        add_row(make_req(OP_NORM, 0, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff),
                1'b1, z);
        add_row(make_req(OP_NORM, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0),
                1'b1, fixed_rsp(0, 0, 0, 0, 16'hffff, 1'b1));
        add_row(make_req(OP_NORM, 16'h4000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                fixed_rsp(0, 0, 0, 0, 16'h4000, 1'b0));
        add_row(make_req(OP_NORM, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0),
                1'b1, fixed_rsp(0, 0, 0, 0, 16'hfffe, 1'b0));
        add_row(make_req(OP_NORM, 16'h0003, 16'hfffc, 0, 0, 0, 0, 0, 0), 1'b1,
                fixed_rsp(0, 0, 0, 0, 16'h0005, 1'b0));
        add_row(make_req(OP_NORM, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 0, 0, 0, 0),
                1'b0, z);
    endtask

    initial begin
        t_req q;
        int gap_mode;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_req = '0;
        n_sent = 0;
        stim_done = 1'b0;
        hold_on = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;
        build_rows();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rows[k]) begin
            if ($urandom_range(0, 99) < 16) idle_input();
            transfer_req(rows[k].req,
                         rows[k].known ? rows[k].rsp : quat_result(rows[k].req));
        end
        for (int n = 0; n < NumRandom; n++) begin
            gap_mode = (n >= 400 && n < 700) ? 0 : 16;
            if (n == 100) hold_on = 1'b1;
            if (n == 1000) begin
                push <= 1'b0;
                while (expected_q.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < gap_mode) idle_input();
            q = random_req();
            transfer_req(q, quat_result(q));
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int hold_cnt;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_on && !hold_done) begin
                pop <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HoldCycles) begin
                    @(negedge i_clk);
                    hold_cnt++;
                end
                hold_done = 1'b1;
            end else if (n_sent > 1100 && n_sent < 1400) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.saturated) n_sat++;
                if (o_rsp.res_w !== want.res_w) begin
                    $error("res_w expected %h actual %h", want.res_w, o_rsp.res_w);
                    n_fail++;
                end
                if (o_rsp.res_x !== want.res_x) begin
                    $error("res_x expected %h actual %h", want.res_x, o_rsp.res_x);
                    n_fail++;
                end
                if (o_rsp.res_y !== want.res_y) begin
                    $error("res_y expected %h actual %h", want.res_y, o_rsp.res_y);
                    n_fail++;
                end
                if (o_rsp.res_z !== want.res_z) begin
                    $error("res_z expected %h actual %h", want.res_z, o_rsp.res_z);
                    n_fail++;
                end
                if (o_rsp.norm_value !== want.norm_value) begin
                    $error("norm_value expected %h actual %h", want.norm_value,
                           o_rsp.norm_value);
                    n_fail++;
                end
                if (o_rsp.saturated !== want.saturated) begin
                    $error("saturated expected %b actual %b", want.saturated,
                           o_rsp.saturated);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        n_fail = 0;
        n_checked = 0;
        n_sat = 0;
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Checked %0d transfers: add %0d, product %0d, conjugate %0d, norm %0d.",
                 n_checked, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results were saturated.", n_sat);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qau_pkg.sv
hw/rtl/qau_front.sv
hw/rtl/qau_back.sv
hw/rtl/quaternion_arithmetic_unit.sv
tb/tb_top.sv
